### hw/rtl/kway_key_merge_grouper_unit_macros.svh
// Assertion helpers shared by the merge grouper RTL
`ifndef KWAY_KEY_MERGE_GROUPER_UNIT_MACROS_SVH
`define KWAY_KEY_MERGE_GROUPER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KKMG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KKMG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/kkmg_pkg.sv
package kkmg_pkg;

	// field widths
	localparam int KEY_W = 64;
	localparam int SRC_W = 4;
	localparam int CNT_W = 32;
	localparam int ACT_W = 5;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// default stream count
	localparam int STREAMS_DEF = 16;

	// constants
	localparam logic [KEY_W-1:0] KEY_DONE = {KEY_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

	// register index (paddr[2]) of active_sources
	localparam logic REG_IDX_ACTIVE = 1'b0;

	// controller -> datapath commands
	typedef struct packed {
		logic store;
		logic scan_clr;
		logic scan_step;
		logic load_out;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic scan_end;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/kway_key_merge_grouper_unit.sv
// K-way key merge grouper.
// Input channel (in_valid/in_ready): one word = kind, source, key. The key is
// written as the new head of stream 'source'. kind 0 only stores. kind 1 then
// scans heads 0..N-1 (N = min(active_sources, STREAMS)), one head per cycle
// from the head memory, and emits one result word.
// Output channel (out_valid/out_ready): winner_source, winner_key,
// first_of_group, done_res, distinct_count.
// A select runs from acceptance through the scan state, which reads the
// head memory, and the finish state, which loads the output register; the
// next word is accepted once the controller is back in idle, so a select
// holds the input from its acceptance until its result is registered.
// APB port: active_sources at address 0, reset 16.
// Reset: all heads read as exhausted (all ones), no previous winner, count 0.
// A stalled receiver holds the output word; a following select waits in its
// finish state until the output register is free, with the input held.
module kway_key_merge_grouper_unit #(
	parameter int STREAMS = kkmg_pkg::STREAMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kkmg_pkg::APB_AW-1:0] paddr,
	input  logic [kkmg_pkg::APB_DW-1:0] pwdata,
	output logic [kkmg_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	// input words
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic [kkmg_pkg::SRC_W-1:0]  source,
	input  logic [kkmg_pkg::KEY_W-1:0]  key,
	// result words
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kkmg_pkg::SRC_W-1:0]  winner_source,
	output logic [kkmg_pkg::KEY_W-1:0]  winner_key,
	output logic                        first_of_group,
	output logic                        done_res,
	output logic [kkmg_pkg::CNT_W-1:0]  distinct_count
);
	import kkmg_pkg::*;

	logic [ACT_W-1:0] active_q;
	cmd_t cmd;
	sts_t sts;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_IDX_ACTIVE)) begin
			active_q <= pwdata[ACT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_ACTIVE) ? APB_DW'(active_q) : '0;

	kkmg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kkmg_dp #(
		.STREAMS (STREAMS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.active_sources (active_q),
		.source         (source),
		.key            (key),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.winner_source  (winner_source),
		.winner_key     (winner_key),
		.first_of_group (first_of_group),
		.done_res       (done_res),
		.distinct_count (distinct_count)
	);

endmodule

### hw/rtl/kkmg_ctrl.sv
`include "kway_key_merge_grouper_unit_macros.svh"

module kkmg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            kind,
	output logic            in_ready,
	input  kkmg_pkg::sts_t  sts,
	output kkmg_pkg::cmd_t  cmd
);
	import kkmg_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store = 1'b1;
					if (kind) begin
						cmd.scan_clr = 1'b1;
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					state_nxt = ST_FIN;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`KKMG_ASSERT_NXT(a_scan_exit, state_q == ST_SCAN, state_q == ST_SCAN || state_q == ST_FIN, "scan left to wrong state")
	`KKMG_ASSERT_IMP(a_load_in_fin, cmd.load_out, state_q == ST_FIN, "result loaded outside finish")

endmodule

### hw/rtl/kkmg_dp.sv
`include "kway_key_merge_grouper_unit_macros.svh"

module kkmg_dp #(
	parameter int STREAMS = kkmg_pkg::STREAMS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kkmg_pkg::cmd_t             cmd,
	output kkmg_pkg::sts_t             sts,
	input  logic [kkmg_pkg::ACT_W-1:0] active_sources,
	input  logic [kkmg_pkg::SRC_W-1:0] source,
	input  logic [kkmg_pkg::KEY_W-1:0] key,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [kkmg_pkg::SRC_W-1:0] winner_source,
	output logic [kkmg_pkg::KEY_W-1:0] winner_key,
	output logic                       first_of_group,
	output logic                       done_res,
	output logic [kkmg_pkg::CNT_W-1:0] distinct_count
);
	import kkmg_pkg::*;

	localparam int IDX_W = $clog2(STREAMS);
	localparam int SC_W = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;

	// head store; entries never written read as exhausted
	logic [KEY_W-1:0] heads_mem [STREAMS];
	logic [STREAMS-1:0] head_vld_q;

	logic [SC_W-1:0] scan_idx_q;
	logic [SC_W-1:0] n_play;
	logic            wr_ok;
	logic [IDX_W-1:0] wr_addr;

	logic [KEY_W-1:0] rd_key_s1;
	logic             rd_ok_s1;
	logic [SRC_W-1:0] rd_idx_s1;
	logic             rd_vld_s1;
	logic [KEY_W-1:0] head_s1;

	logic [KEY_W-1:0] best_key_q;
	logic [SRC_W-1:0] best_idx_q;

	logic [KEY_W-1:0] last_key_q;
	logic             has_prev_q;
	logic [CNT_W-1:0] group_cnt_q;
	logic             out_valid_q;

	logic             done;
	logic             first;
	logic [CNT_W-1:0] cnt_nxt;

	// streams in play, capped at the store depth
	assign n_play = (SC_W'(active_sources) > SC_W'(STREAMS)) ? SC_W'(STREAMS)
		: SC_W'(active_sources);

	// store write decode
	assign wr_ok = cmd.store && (SC_W'(source) < SC_W'(STREAMS));
	assign wr_addr = IDX_W'(source);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			heads_mem[wr_addr] <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
		end else if (wr_ok) begin
			head_vld_q[wr_addr] <= 1'b1;
		end
	end

	// scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_clr) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + SC_W'(1);
		end
	end

	// registered head read
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_key_s1 <= heads_mem[scan_idx_q[IDX_W-1:0]];
			rd_ok_s1 <= head_vld_q[scan_idx_q[IDX_W-1:0]];
			rd_idx_s1 <= scan_idx_q[SRC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
		end
	end

	assign head_s1 = rd_ok_s1 ? rd_key_s1 : KEY_DONE;

	// running minimum; strict less keeps the lower index on ties
	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			best_key_q <= KEY_DONE;
			best_idx_q <= '0;
		end else if (rd_vld_s1 && (head_s1 < best_key_q)) begin
			best_key_q <= head_s1;
			best_idx_q <= rd_idx_s1;
		end
	end

	// grouping
	assign done = (best_key_q == KEY_DONE);
	assign first = !has_prev_q || (best_key_q != last_key_q);
	assign cnt_nxt = (first && (group_cnt_q != CNT_MAX)) ? group_cnt_q + CNT_W'(1)
		: group_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q <= '0;
			has_prev_q <= 1'b0;
			group_cnt_q <= '0;
		end else if (cmd.load_out && !done) begin
			last_key_q <= best_key_q;
			has_prev_q <= 1'b1;
			group_cnt_q <= cnt_nxt;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			winner_source <= done ? '0 : best_idx_q;
			winner_key <= best_key_q;
			first_of_group <= !done && first;
			done_res <= done;
			distinct_count <= done ? group_cnt_q : cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign sts.scan_end = (scan_idx_q == n_play);
	assign sts.out_free = !out_valid_q || out_ready;

	`KKMG_ASSERT_IMP(a_load_free, cmd.load_out, !out_valid_q || out_ready, "result overwrites a pending word")
	`KKMG_ASSERT_IMP(a_scan_bound, cmd.scan_step, scan_idx_q < n_play, "scan past active streams")
	`KKMG_ASSERT_NXT(a_cnt_mono, 1'b1, group_cnt_q >= $past(group_cnt_q), "distinct count went down")

endmodule
